@@ rtl/core/cslx_pkg.sv @@
// Shared types, character codes and byte classifiers for the C source byte lexer.
`timescale 1ns / 1ps

package cslx_pkg;

	// Scanner modes between and inside tokens
	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_IDENT  = 3'd1,
		MODE_STRING = 3'd2,
		MODE_LINE   = 3'd3,
		MODE_BLOCK  = 3'd4,
		MODE_STAR   = 3'd5,
		MODE_SLASH  = 3'd6,
		MODE_COLON  = 3'd7
	} scan_mode_t;

	// Token kind codes as seen on the output channel
	typedef enum logic [3:0] {
		KIND_UNKNOWN = 4'd0,
		KIND_LPAREN  = 4'd1,
		KIND_RPAREN  = 4'd2,
		KIND_LBRACE  = 4'd3,
		KIND_RBRACE  = 4'd4,
		KIND_LBRACK  = 4'd5,
		KIND_RBRACK  = 4'd6,
		KIND_IDENT   = 4'd7,
		KIND_STRING  = 4'd8,
		KIND_SEMI    = 4'd9,
		KIND_COLON   = 4'd10,
		KIND_STAR    = 4'd11,
		KIND_NSPACE  = 4'd12,
		KIND_EQUALS  = 4'd13,
		KIND_END     = 4'd14
	} token_kind_t;

	localparam int unsigned TOK_BITS    = 16;
	localparam logic [15:0] LEN_MAX     = 16'hFFFF;
	localparam int unsigned SLOTS       = 4;
	localparam int unsigned SLOT_BITS   = 2;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_BITS   = 2;
	localparam int unsigned QCNT_BITS   = 3;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// One token as it moves through the queue
	typedef struct packed {
		token_kind_t        kind;
		logic [TOK_BITS-1:0] start;
		logic [TOK_BITS-1:0] length;
	} tok_t;

	// All tokens caused by one byte, in output order, slot 0 first
	typedef struct packed {
		logic [SLOTS-1:0] mask;
		tok_t [SLOTS-1:0] slot;
	} bundle_t;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {[8'h30:8'h39]});
	endfunction

	function automatic logic is_eol(input logic [7:0] c);
		return (c inside {CH_LF, CH_CR});
	endfunction

	// space, TAB, LF, VT, FF, CR
	function automatic logic is_space(input logic [7:0] c);
		return (c inside {8'h20, [8'h09:8'h0D]});
	endfunction

	function automatic logic is_ident_cont(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
	endfunction

	// Kind of a single-byte token
	function automatic token_kind_t punct_kind(input logic [7:0] c);
		token_kind_t k;
		case (c)
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_LBRACK: k = KIND_LBRACK;
			CH_RBRACK: k = KIND_RBRACK;
			CH_SEMI:   k = KIND_SEMI;
			CH_STAR:   k = KIND_STAR;
			CH_EQUALS: k = KIND_EQUALS;
			default:   k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

@@ rtl/core/cslx_byte_if.sv @@
// Valid/ready channel that carries source text bytes.
`timescale 1ns / 1ps

interface cslx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ rtl/core/cslx_token_if.sv @@
// Valid/ready channel that carries lexer tokens.
`timescale 1ns / 1ps

interface cslx_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input last_of_run, output ready);
endinterface

@@ rtl/core/cslx_front.sv @@
// Lexer front: accepts bytes, tracks scan mode and emits a token bundle for each byte that yields tokens.
`timescale 1ns / 1ps

module cslx_front import cslx_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	cslx_byte_if.sink    text,
	input  qstat_t       qstat,
	output logic         push,
	output bundle_t      push_data
);

	scan_mode_t               mode_q, mode_mid, mode_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d, begin_q, begin_mid, begin_d, pos_next;
	logic [TOK_BITS-1:0]      len_q, len_mid, len_d;
	logic                     fresh;
	logic                     acc;
	logic [7:0]               c;
	logic                     eot;

	assign c          = text.text_byte;
	assign eot        = text.end_of_text;
	assign text.ready = !qstat.full;
	assign acc        = text.valid && text.ready;
	assign pos_next   = pos_q + 1'b1;
	assign push       = acc && (push_data.mask != '0);

	// Next state: mode after this byte, then end-of-text return to reset
	always_comb begin
		mode_mid  = mode_q;
		begin_mid = begin_q;
		len_mid   = len_q;
		fresh     = 1'b0;
		case (mode_q)
			MODE_IDENT: begin
				if (is_ident_cont(c)) begin
					if (len_q != LEN_MAX) len_mid = len_q + 1'b1;
				end else begin
					mode_mid = MODE_NORMAL;
					fresh    = 1'b1;
				end
			end
			MODE_STRING: begin
				if (c == CH_QUOTE) begin
					mode_mid = MODE_NORMAL;
				end else if (len_q != LEN_MAX) begin
					len_mid = len_q + 1'b1;
				end
			end
			MODE_LINE: begin
				if (is_eol(c)) mode_mid = MODE_NORMAL;
			end
			MODE_BLOCK: begin
				if (c == CH_STAR) mode_mid = MODE_STAR;
			end
			MODE_STAR: begin
				if (c == CH_SLASH) mode_mid = MODE_NORMAL;
				else if (c != CH_STAR) mode_mid = MODE_BLOCK;
			end
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					mode_mid = MODE_LINE;
				end else if (c == CH_STAR) begin
					mode_mid = MODE_BLOCK;
				end else begin
					mode_mid = MODE_NORMAL;
					fresh    = 1'b1;
				end
			end
			MODE_COLON: begin
				mode_mid = MODE_NORMAL;
				fresh    = (c != CH_COLON);
			end
			default: fresh = 1'b1;
		endcase

		// byte that starts something between tokens
		if (fresh && !is_space(c)) begin
			if (c == CH_SLASH) begin
				mode_mid  = MODE_SLASH;
				begin_mid = pos_q;
			end else if (c == CH_COLON) begin
				mode_mid  = MODE_COLON;
				begin_mid = pos_q;
			end else if (c == CH_QUOTE) begin
				mode_mid  = MODE_STRING;
				begin_mid = pos_next;
				len_mid   = '0;
			end else if (is_alpha(c) || (c == CH_TILDE)) begin
				mode_mid  = MODE_IDENT;
				begin_mid = pos_q;
				len_mid   = TOK_BITS'(1);
			end
		end

		if (eot) begin
			mode_d  = MODE_NORMAL;
			pos_d   = '0;
			begin_d = '0;
			len_d   = '0;
		end else begin
			mode_d  = mode_mid;
			pos_d   = pos_next;
			begin_d = begin_mid;
			len_d   = len_mid;
		end
	end

	// Outputs: closing token, single-byte token, end-of-text flush, end token
	always_comb begin
		push_data = '0;

		case (mode_q)
			MODE_IDENT: begin
				push_data.mask[0] = !is_ident_cont(c);
				push_data.slot[0] = '{KIND_IDENT, TOK_BITS'(begin_q), len_q};
			end
			MODE_STRING: begin
				push_data.mask[0] = (c == CH_QUOTE);
				push_data.slot[0] = '{KIND_STRING, TOK_BITS'(begin_q), len_q};
			end
			MODE_SLASH: begin
				push_data.mask[0] = (c != CH_SLASH) && (c != CH_STAR);
				push_data.slot[0] = '{KIND_UNKNOWN, TOK_BITS'(begin_q), TOK_BITS'(1)};
			end
			MODE_COLON: begin
				push_data.mask[0] = 1'b1;
				if (c == CH_COLON)
					push_data.slot[0] = '{KIND_NSPACE, TOK_BITS'(begin_q), TOK_BITS'(2)};
				else
					push_data.slot[0] = '{KIND_COLON, TOK_BITS'(begin_q), TOK_BITS'(1)};
			end
			default: push_data.mask[0] = 1'b0;
		endcase

		push_data.mask[1] = fresh && !is_space(c) && (c != CH_SLASH) && (c != CH_COLON)
			&& (c != CH_QUOTE) && !is_alpha(c) && (c != CH_TILDE);
		push_data.slot[1] = '{punct_kind(c), TOK_BITS'(pos_q), TOK_BITS'(1)};

		case (mode_mid)
			MODE_IDENT: begin
				push_data.mask[2] = eot;
				push_data.slot[2] = '{KIND_IDENT, TOK_BITS'(begin_mid), len_mid};
			end
			MODE_STRING: begin
				push_data.mask[2] = eot;
				push_data.slot[2] = '{KIND_STRING, TOK_BITS'(begin_mid), len_mid};
			end
			MODE_SLASH: begin
				push_data.mask[2] = eot;
				push_data.slot[2] = '{KIND_UNKNOWN, TOK_BITS'(begin_mid), TOK_BITS'(1)};
			end
			MODE_COLON: begin
				push_data.mask[2] = eot;
				push_data.slot[2] = '{KIND_COLON, TOK_BITS'(begin_mid), TOK_BITS'(1)};
			end
			default: push_data.mask[2] = 1'b0;
		endcase

		push_data.mask[3] = eot;
		push_data.slot[3] = '{KIND_END, TOK_BITS'(pos_next), '0};
	end

	// Scanner registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			pos_q   <= '0;
			begin_q <= '0;
			len_q   <= '0;
		end else if (acc) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			begin_q <= begin_d;
			len_q   <= len_d;
		end
	end

	// End of text leaves the scanner as after reset
	a_eot_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && eot) |=> (mode_q == MODE_NORMAL) && (pos_q == '0) && (len_q == '0))
		else $error("scanner not cleared after end of text");

	// Position advances by one on each ordinary byte
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !eot) |=> (pos_q == POSITION_BITS'($past(pos_q) + 1'b1)))
		else $error("byte position did not advance");

	// A byte never yields all four candidate tokens
	a_max_three: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (push_data.mask != 4'b1111))
		else $error("more than three tokens for one byte");

endmodule

@@ rtl/core/cslx_queue.sv @@
// Short queue of token bundles between the lexer front and back.
`timescale 1ns / 1ps

module cslx_queue import cslx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output bundle_t pop_data,
	output qstat_t  qstat
);

	bundle_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign pop_data    = entry_q[rd_ptr_q];
	assign qstat.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	// Entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

@@ rtl/core/cslx_back.sv @@
// Lexer back: splits token bundles into single token transfers.
`timescale 1ns / 1ps

module cslx_back import cslx_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  qstat_t       qstat,
	input  bundle_t      pop_data,
	output logic         pop,
	cslx_token_if.source token
);

	logic                 hold_valid_q;
	logic [SLOTS-1:0]     hold_mask_q;
	tok_t [SLOTS-1:0]     hold_slot_q;
	logic [SLOT_BITS-1:0] pick;
	logic [SLOTS-1:0]     rest;
	logic                 out_free;
	logic                 fire;
	logic                 out_valid_q;
	tok_t                 out_tok_q;
	logic                 out_last_q;

	// Lowest pending slot goes out first
	always_comb begin
		pick = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hold_mask_q[i]) pick = SLOT_BITS'(i);
		end
	end

	assign rest     = hold_mask_q & ~(SLOTS'(1) << pick);
	assign out_free = !out_valid_q || token.ready;
	assign fire     = hold_valid_q && out_free;
	assign pop      = !qstat.empty && (!hold_valid_q || (fire && (rest == '0)));

	// Bundle hold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			hold_mask_q  <= '0;
		end else if (pop) begin
			hold_valid_q <= 1'b1;
			hold_mask_q  <= pop_data.mask;
		end else if (fire) begin
			hold_valid_q <= (rest != '0);
			hold_mask_q  <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) hold_slot_q <= pop_data.slot;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (token.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_tok_q  <= hold_slot_q[pick];
			out_last_q <= (rest == '0);
		end
	end

	assign token.valid        = out_valid_q;
	assign token.token_kind   = out_tok_q.kind;
	assign token.token_start  = out_tok_q.start;
	assign token.token_length = out_tok_q.length;
	assign token.last_of_run  = out_last_q;

	// A shown token that is not the last leaves the rest of its bundle held
	a_run_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> hold_valid_q)
		else $error("bundle lost before its last token");

	a_hold_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> (hold_mask_q != '0))
		else $error("held bundle has no pending token");

	a_pop_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && hold_valid_q) |-> (fire && (rest == '0)))
		else $error("bundle replaced while tokens remain");

endmodule

@@ rtl/core/c_source_byte_lexer.sv @@
// Top level: front scanner, bundle queue and token serializer.
// A byte's first token passes the queue entry, hold register and output register.
// Throughput: one byte and one token per cycle while the receiver is ready; a byte
// that causes two or three tokens holds the output for each in turn, absorbed by a
// four-bundle queue between front and back, input stalls only when it fills.
// Reset (arst_n low) clears scan mode, position, queue and output valid at once.
`timescale 1ns / 1ps

module c_source_byte_lexer import cslx_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	cslx_byte_if.sink    text,
	cslx_token_if.source token
);

	qstat_t  qstat;
	logic    push;
	logic    pop;
	bundle_t push_data;
	bundle_t pop_data;

	cslx_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	cslx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	cslx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_data (pop_data),
		.pop      (pop),
		.token    (token)
	);

endmodule
